// ----- design/running_min_max_mean_assert.svh -----
// Assertion macros used by the running_min_max_mean controller (rmm_ctrl).
`ifndef RUNNING_MIN_MAX_MEAN_ASSERT_SVH
`define RUNNING_MIN_MAX_MEAN_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define RMM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("running_min_max_mean: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define RMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("running_min_max_mean: next-cycle check failed");

`endif

// ----- design/rmm_pkg.sv -----
`default_nettype none

package rmm_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int SUM_OUT_W  = 39;
    localparam int CNT_OUT_W  = 8;
    localparam int TDATA_W    = 144;   // 143 payload bits padded to whole bytes
    localparam int TDATA_PAD  = TDATA_W - 3 * SAMPLE_W - SUM_OUT_W - CNT_OUT_W;

    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_START,
        ST_DIVIDE,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic accept;     // sample transaction taken this cycle
        logic start_div;  // launch mean division on the final sum/count
        logic load_out;   // capture result into output register, clear set
    } cmd_t;

    typedef struct packed {
        logic div_done;   // quotient valid this cycle
    } status_t;

endpackage

`default_nettype wire

// ----- design/rmm_divider.sv -----
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module rmm_divider #(
    parameter int DIVIDEND_W = 39,
    parameter int DIVISOR_W  = 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic      [DIVIDEND_W-1:0] quotient,
    output logic                       done
);

    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;

    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, divisor};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = STEP_W'(DIVIDEND_W);
            quo_next  = dividend;
            rem_next  = '0;
        end else if (busy_reg) begin
            if (trial >= {1'b0, divisor}) begin
                rem_next = diff[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

// ----- design/rmm_datapath.sv -----
`default_nettype none

module rmm_datapath #(
    parameter int MAX_ITEMS = 128
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire rmm_pkg::cmd_t                       cmd,
    output rmm_pkg::status_t                         status,
    input  wire logic signed [rmm_pkg::SAMPLE_W-1:0] sample,
    output logic signed [rmm_pkg::SAMPLE_W-1:0]      max_value,
    output logic signed [rmm_pkg::SAMPLE_W-1:0]      min_value,
    output logic signed [rmm_pkg::SAMPLE_W-1:0]      mean_value,
    output logic signed [rmm_pkg::SUM_OUT_W-1:0]     sum_value,
    output logic [rmm_pkg::CNT_OUT_W-1:0]            item_count,
    output logic                                     overflow_flag
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int SUM_W = rmm_pkg::SAMPLE_W + $clog2(MAX_ITEMS);

    logic signed [rmm_pkg::SAMPLE_W-1:0]  max_reg, max_next;
    logic signed [rmm_pkg::SAMPLE_W-1:0]  min_reg, min_next;
    logic signed [SUM_W-1:0]              sum_reg, sum_next;
    logic [CNT_W-1:0]                     count_reg, count_next;
    logic                                 drop_reg, drop_next;

    logic signed [rmm_pkg::SAMPLE_W-1:0]  max_out_reg, min_out_reg, mean_out_reg;
    logic signed [rmm_pkg::SUM_OUT_W-1:0] sum_out_reg;
    logic [rmm_pkg::CNT_OUT_W-1:0]        count_out_reg;
    logic                                 drop_out_reg;

    logic                                 sum_neg;
    logic [SUM_W-1:0]                     sum_mag;
    logic [SUM_W-1:0]                     quotient;
    logic [rmm_pkg::SAMPLE_W-1:0]         quo_low;
    logic signed [rmm_pkg::SAMPLE_W-1:0]  mean;
    logic                                 div_done;

    // Divide magnitudes, then restore the sign: truncation toward zero.
    assign sum_neg = sum_reg[SUM_W-1];
    assign sum_mag = sum_neg ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);

    rmm_divider #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.start_div),
        .dividend (sum_mag),
        .divisor  (count_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    assign quo_low = quotient[rmm_pkg::SAMPLE_W-1:0];
    assign mean    = sum_neg ? $signed(-quo_low) : $signed(quo_low);

    always_comb begin
        max_next   = max_reg;
        min_next   = min_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        drop_next  = drop_reg;
        if (cmd.load_out) begin
            sum_next   = '0;
            count_next = '0;
            drop_next  = 1'b0;
        end else if (cmd.accept) begin
            if (count_reg < CNT_W'(MAX_ITEMS)) begin
                if (count_reg == '0) begin
                    max_next = sample;
                    min_next = sample;
                end else begin
                    if (sample > max_reg) max_next = sample;
                    if (sample < min_reg) min_next = sample;
                end
                sum_next   = sum_reg + SUM_W'(sample);
                count_next = count_reg + 1'b1;
            end else begin
                drop_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            count_reg <= '0;
            drop_reg  <= 1'b0;
        end else begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
            drop_reg  <= drop_next;
        end
        max_reg <= max_next;
        min_reg <= min_next;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            max_out_reg   <= max_reg;
            min_out_reg   <= min_reg;
            mean_out_reg  <= mean;
            sum_out_reg   <= rmm_pkg::SUM_OUT_W'(sum_reg);
            count_out_reg <= rmm_pkg::CNT_OUT_W'(count_reg);
            drop_out_reg  <= drop_reg;
        end
    end

    assign status.div_done = div_done;
    assign max_value       = max_out_reg;
    assign min_value       = min_out_reg;
    assign mean_value      = mean_out_reg;
    assign sum_value       = sum_out_reg;
    assign item_count      = count_out_reg;
    assign overflow_flag   = drop_out_reg;

endmodule

`default_nettype wire

// ----- design/rmm_ctrl.sv -----
`default_nettype none

`include "running_min_max_mean_assert.svh"

module rmm_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    input  wire logic             s_tlast,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output rmm_pkg::cmd_t         cmd,
    input  wire rmm_pkg::status_t status
);

    rmm_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_free;
    logic            take;

    assign out_free = !out_valid_reg || m_tready;
    assign take     = s_tvalid && (state_reg == rmm_pkg::ST_ACCUM);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rmm_pkg::ST_ACCUM: begin
                if (take && s_tlast) state_next = rmm_pkg::ST_START;
            end
            rmm_pkg::ST_START: begin
                state_next = rmm_pkg::ST_DIVIDE;
            end
            rmm_pkg::ST_DIVIDE: begin
                if (status.div_done) state_next = rmm_pkg::ST_LOAD;
            end
            rmm_pkg::ST_LOAD: begin
                if (out_free) state_next = rmm_pkg::ST_ACCUM;
            end
            default: begin
                state_next = rmm_pkg::ST_ACCUM;
            end
        endcase
    end

    // outputs
    always_comb begin
        cmd       = '0;
        s_tready  = 1'b0;
        case (state_reg)
            rmm_pkg::ST_ACCUM: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            rmm_pkg::ST_START: begin
                cmd.start_div = 1'b1;
            end
            rmm_pkg::ST_DIVIDE: begin
                cmd = '0;
            end
            rmm_pkg::ST_LOAD: begin
                cmd.load_out = out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)   out_valid_next = 1'b1;
        else if (m_tready)  out_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rmm_pkg::ST_ACCUM;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

    `RMM_ASSERT_NOW(a_load_needs_free_slot, aclk, aresetn, cmd.load_out, out_free)
    `RMM_ASSERT_NEXT(a_last_starts_divide, aclk, aresetn, take && s_tlast, cmd.start_div)
    `RMM_ASSERT_NOW(a_done_only_when_dividing, aclk, aresetn, status.div_done,
                    state_reg == rmm_pkg::ST_DIVIDE)
    `RMM_ASSERT_NEXT(a_load_shows_result, aclk, aresetn, cmd.load_out,
                     m_tvalid && s_tready)

endmodule

`default_nettype wire

// ----- design/running_min_max_mean.sv -----
// Running min / max / sum / mean over sets of signed 32-bit samples. One sample
// transaction is taken per clock while a set is being collected; s_tlast marks the
// last sample of a set. On that sample the block divides the exact sum by the count
// in a bit-serial divider (one quotient bit per clock over the 32+log2(MAX_ITEMS)
// bit sum), so after a marked sample s_tready stays low while the division runs
// and its result is loaded, before the next set may start, and longer while the
// previous result still waits in the output register, since the new result is
// loaded only once that one is taken. The result then sits in the output register
// until taken, and the next set is collected meanwhile. Samples beyond MAX_ITEMS in
// one set are dropped and flagged in m_tuser; a marked dropped sample still closes
// the set. The mean is truncated toward zero. With MAX_ITEMS above 128 the count
// and sum fields carry the low 8 and 39 bits.
`default_nettype none

module running_min_max_mean #(
    parameter int MAX_ITEMS = 128
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // sample stream
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [rmm_pkg::SAMPLE_W-1:0] s_tdata,   // [31:0] sample
    input  wire logic                         s_tlast,   // last sample of the set
    // result stream
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // [31:0] max_value, [63:32] min_value, [95:64] mean_value,
    // [134:96] sum_value, [142:135] item_count, [143] zero
    output logic [rmm_pkg::TDATA_W-1:0]       m_tdata,
    output logic [0:0]                        m_tuser    // [0] overflow_flag
);

    rmm_pkg::cmd_t    cmd;
    rmm_pkg::status_t status;

    logic signed [rmm_pkg::SAMPLE_W-1:0]  max_value;
    logic signed [rmm_pkg::SAMPLE_W-1:0]  min_value;
    logic signed [rmm_pkg::SAMPLE_W-1:0]  mean_value;
    logic signed [rmm_pkg::SUM_OUT_W-1:0] sum_value;
    logic [rmm_pkg::CNT_OUT_W-1:0]        item_count;
    logic                                 overflow_flag;

    // Controller: sequences collect / divide / load and owns the output valid.
    rmm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    // Datapath: running statistics, divider and result register.
    rmm_datapath #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .sample        ($signed(s_tdata)),
        .max_value     (max_value),
        .min_value     (min_value),
        .mean_value    (mean_value),
        .sum_value     (sum_value),
        .item_count    (item_count),
        .overflow_flag (overflow_flag)
    );

    assign m_tdata = {{rmm_pkg::TDATA_PAD{1'b0}}, item_count, sum_value,
                      mean_value, min_value, max_value};
    assign m_tuser = overflow_flag;

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`default_nettype none

module tb_top;

    localparam int SAMPLE_W     = rmm_pkg::SAMPLE_W;
    localparam int SUM_OUT_W    = rmm_pkg::SUM_OUT_W;
    localparam int CNT_OUT_W    = rmm_pkg::CNT_OUT_W;
    localparam int TDATA_W      = rmm_pkg::TDATA_W;

    localparam int SET_LIMIT    = 128;          // MAX_ITEMS of the instance under test
    localparam int SAMPLE_MAX   = 2147483647;
    localparam int SAMPLE_MIN   = -2147483647 - 1;
    localparam int HOLD_CYCLES  = 400;          // long receiver hold-off
    localparam int DRAIN_CYCLES = 60;           // longer than the divide and load of a set
    localparam int CYCLE_LIMIT  = 300000;

    // m_tdata field offsets, lowest field first
    localparam int MAX_LSB  = 0;
    localparam int MIN_LSB  = SAMPLE_W;
    localparam int MEAN_LSB = 2 * SAMPLE_W;
    localparam int SUM_LSB  = 3 * SAMPLE_W;
    localparam int CNT_LSB  = SUM_LSB + SUM_OUT_W;

    typedef struct {
        logic signed [SAMPLE_W-1:0]  max_value;
        logic signed [SAMPLE_W-1:0]  min_value;
        logic signed [SAMPLE_W-1:0]  mean_value;
        logic signed [SUM_OUT_W-1:0] sum_value;
        logic [CNT_OUT_W-1:0]        item_count;
        logic                        overflow_flag;
    } set_stats_t;

    typedef int sample_q_t[$];

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [SAMPLE_W-1:0]  s_tdata  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;
    logic [0:0]           m_tuser;

    // predictor state for the set being collected
    int                   acc_max;
    int                   acc_min;
    longint               acc_sum     = 0;
    int                   acc_count   = 0;
    logic                 acc_dropped = 1'b0;

    set_stats_t           pending_stats[$];   // expected results, oldest first
    int                   fail_count  = 0;
    int                   cycle_count = 0;

    // traffic shaping shared by the sender, the sink and the test tasks
    int                   burst_left  = 0;
    bit                   quiet       = 1'b0;  // no idling on either side
    bit                   hold_req    = 1'b0;  // ask the sink for a long hold-off

    running_min_max_mean #(
        .MAX_ITEMS (SET_LIMIT)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [31:0] sample
        .s_tlast  (s_tlast),    // last sample of the set
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // max, min, mean, sum, count, pad
        .m_tuser  (m_tuser)     // [0] overflow_flag
    );

    always #6 aclk = ~aclk;

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // Fold one accepted sample into the running statistics; a marked sample
    // closes the set and queues the result the block must produce.
    function automatic void update_stats(input int value, input logic is_last);
        set_stats_t r;
        longint     quotient;
        if (acc_count < SET_LIMIT) begin
            // first sample of a set seeds both extremes
            if (acc_count == 0) begin
                acc_max = value;
                acc_min = value;
            end else begin
                if (value > acc_max) acc_max = value;
                if (value < acc_min) acc_min = value;
            end
            acc_sum   += value;
            acc_count += 1;
        end else begin
            // set already full: sample dropped, but a mark still closes the set
            acc_dropped = 1'b1;
        end
        if (is_last) begin
            quotient        = acc_sum / longint'(acc_count);   // truncates toward zero
            r.max_value     = acc_max;
            r.min_value     = acc_min;
            r.mean_value    = quotient[SAMPLE_W-1:0];
            r.sum_value     = acc_sum[SUM_OUT_W-1:0];
            r.item_count    = acc_count[CNT_OUT_W-1:0];
            r.overflow_flag = acc_dropped;
            pending_stats.push_back(r);
            acc_sum     = 0;
            acc_count   = 0;
            acc_dropped = 1'b0;
        end
    endfunction

    // Compare one result transaction against the oldest expectation.
    task automatic check_stats();
        set_stats_t want;
        set_stats_t got;
        got.max_value     = m_tdata[MAX_LSB  +: SAMPLE_W];
        got.min_value     = m_tdata[MIN_LSB  +: SAMPLE_W];
        got.mean_value    = m_tdata[MEAN_LSB +: SAMPLE_W];
        got.sum_value     = m_tdata[SUM_LSB  +: SUM_OUT_W];
        got.item_count    = m_tdata[CNT_LSB  +: CNT_OUT_W];
        got.overflow_flag = m_tuser[0];
        if (pending_stats.size() == 0) begin
            $error("result transaction with no result expected");
            fail_count++;
        end else begin
            want = pending_stats.pop_front();
            if (got.max_value !== want.max_value) begin
                $error("max_value: expected %0d, got %0d", want.max_value, got.max_value);
                fail_count++;
            end
            if (got.min_value !== want.min_value) begin
                $error("min_value: expected %0d, got %0d", want.min_value, got.min_value);
                fail_count++;
            end
            if (got.mean_value !== want.mean_value) begin
                $error("mean_value: expected %0d, got %0d", want.mean_value, got.mean_value);
                fail_count++;
            end
            if (got.sum_value !== want.sum_value) begin
                $error("sum_value: expected %0d, got %0d", want.sum_value, got.sum_value);
                fail_count++;
            end
            if (got.item_count !== want.item_count) begin
                $error("item_count: expected %0d, got %0d", want.item_count, got.item_count);
                fail_count++;
            end
            if (got.overflow_flag !== want.overflow_flag) begin
                $error("overflow_flag: expected %0d, got %0d",
                       want.overflow_flag, got.overflow_flag);
                fail_count++;
            end
        end
    endtask

    // Result sink: checks every transaction and shapes m_tready. Normally it
    // alternates ready and stall runs of random length; a hold request drops
    // m_tready for HOLD_CYCLES so the block backs up and stalls its input.
    initial begin : result_sink
        int  hold_left;
        int  phase_left;
        bit  sink_busy;
        hold_left  = 0;
        phase_left = 0;
        sink_busy  = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready)
                check_stats();
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (quiet) begin
                m_tready <= 1'b1;
            end else begin
                if (phase_left == 0) begin
                    sink_busy  = !sink_busy;
                    phase_left = sink_busy ? $urandom_range(1, 5) : $urandom_range(1, 10);
                end
                phase_left--;
                m_tready <= !sink_busy;
            end
        end
    end

    // Offer one sample and wait for its transaction. Bursts of random length
    // with random gaps; s_tvalid stays high across back-to-back items.
    task automatic send_sample(input int value, input logic is_last);
        int gap;
        if (!quiet && burst_left == 0) begin
            gap        = $urandom_range(1, 6);
            burst_left = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        if (burst_left > 0)
            burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= is_last;
        do @(posedge aclk); while (!s_tready);
        update_stats(value, is_last);
    endtask

    task automatic send_set(input sample_q_t values);
        foreach (values[i])
            send_sample(values[i], i == values.size() - 1);
    endtask

    // Mix of extremes, tiny values and full-range random words.
    function automatic int rand_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return int'($urandom_range(0, 40)) - 20;
            3:       return int'($urandom_range(0, 2)) - 1;
            default: return int'($urandom);
        endcase
    endfunction

    task automatic send_random_set(input int len);
        for (int i = 0; i < len; i++)
            send_sample(rand_sample(), i == len - 1);
    endtask

    // Single-sample sets at the extremes, truncation of negative and
    // positive means, mixed rising and falling extremes.
    task automatic test_directed_sets();
        send_set('{SAMPLE_MAX});
        send_set('{SAMPLE_MIN});
        send_set('{0});
        send_set('{-1});
        send_set('{-7, 2});
        send_set('{3, 4});
        send_set('{SAMPLE_MIN, SAMPLE_MAX});
        send_set('{5, -3, 9, -11, 1});
        send_set('{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX});
        send_set('{SAMPLE_MIN, SAMPLE_MIN, 1});
    endtask

    task automatic test_random_sets();
        for (int n = 0; n < 30; n++)
            send_random_set($urandom_range(1, 16));
    endtask

    // Full sets at both sum extremes, then sets running past the limit with
    // the mark on a dropped sample.
    task automatic test_limit_sets();
        for (int i = 0; i < SET_LIMIT; i++)
            send_sample(SAMPLE_MAX, i == SET_LIMIT - 1);
        for (int i = 0; i < SET_LIMIT; i++)
            send_sample(SAMPLE_MIN, i == SET_LIMIT - 1);
        send_random_set(SET_LIMIT + 3);
        send_random_set(SET_LIMIT + 1);
    endtask

    // Back-to-back transactions on both sides, short sets.
    task automatic test_back_to_back();
        quiet = 1'b1;
        for (int n = 0; n < 20; n++)
            send_random_set($urandom_range(1, 8));
        quiet = 1'b0;
    endtask

    // Sink holds off while several sets keep coming: output register and
    // divider fill, then s_tready must drop until the sink resumes.
    task automatic test_output_backpressure();
        hold_req = 1'b1;
        for (int n = 0; n < 5; n++)
            send_random_set($urandom_range(3, 10));
    endtask

    initial begin : stimulus
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_sets();
        test_random_sets();
        test_output_backpressure();
        test_limit_sets();
        test_back_to_back();
        test_random_sets();

        s_tvalid <= 1'b0;
        while (pending_stats.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && pending_stats.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
